@@ rtl/lsbse_pkg.sv @@
package lsbse_pkg;

    localparam int MSG_BYTES   = 1024;
    localparam int QUEUE_DEPTH = 4;
    localparam int BANKS       = 4;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_PIXEL = 1'b1;

    typedef enum logic [1:0] {
        REG_BITS_PER_COMPONENT = 2'd0,
        REG_ALL_CHANNELS       = 2'd1,
        REG_MESSAGE_LENGTH     = 2'd2,
        REG_PIXEL_COUNT        = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic       cmd;
        logic [9:0] byte_address;
        logic [7:0] message_byte;
        logic       frame_start;
        logic [7:0] in_blue;
        logic [7:0] in_green;
        logic [7:0] in_red;
    } item_t;

    typedef struct packed {
        logic [7:0] out_blue;
        logic [7:0] out_green;
        logic [7:0] out_red;
        logic       capacity_error;
    } result_t;

    typedef struct packed {
        logic [3:0]  bits_per_component;
        logic        all_channels;
        logic [10:0] message_length;
        logic [23:0] pixel_count;
    } cfg_t;

    typedef struct packed {
        logic        cmd;
        logic [9:0]  byte_address;
        logic [7:0]  message_byte;
        logic        capacity_error;
        logic        use_blue;
        logic        use_green;
        logic        use_red;
        logic [23:0] bit_position;
        logic [7:0]  blue;
        logic [7:0]  green;
        logic [7:0]  red;
    } entry_t;

endpackage

@@ rtl/lsbse_front.sv @@
module lsbse_front #(
    parameter int MSG_BYTES = lsbse_pkg::MSG_BYTES
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  lsbse_pkg::cfg_index_t  cfg_index,
    input  logic [23:0]            cfg_data,
    input  logic                   push,
    input  lsbse_pkg::item_t       item,
    input  logic                   q_full,
    output logic                   q_push,
    output lsbse_pkg::entry_t      q_entry,
    output lsbse_pkg::cfg_t        cfg
);

    localparam int LW = $clog2(MSG_BYTES + 1);
    localparam int BW = LW + 3;

    lsbse_pkg::cfg_t cfg_reg;
    lsbse_pkg::cfg_t cfg_next;
    logic [23:0]     pos_reg;
    logic [23:0]     pos_next;

    logic [LW-1:0] len_sat;
    logic [BW-1:0] total_bits;
    logic          bad;
    logic [23:0]   p0;
    logic [25:0]   q0;
    logic [25:0]   q1;
    logic [25:0]   q2;
    logic [25:0]   tb;
    logic          h0;
    logic          h1;
    logic          h2;
    logic [5:0]    b1x;
    logic [5:0]    b2x;
    logic [5:0]    b3x;
    logic [5:0]    adv;
    logic          pixel_accept;

    assign cfg = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                lsbse_pkg::REG_BITS_PER_COMPONENT: cfg_next.bits_per_component = cfg_data[3:0];
                lsbse_pkg::REG_ALL_CHANNELS:       cfg_next.all_channels       = cfg_data[0];
                lsbse_pkg::REG_MESSAGE_LENGTH:     cfg_next.message_length     = cfg_data[10:0];
                lsbse_pkg::REG_PIXEL_COUNT:        cfg_next.pixel_count        = cfg_data[23:0];
                default:                           cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        if (32'(cfg_reg.message_length) > 32'(MSG_BYTES))
            len_sat = LW'(MSG_BYTES);
        else
            len_sat = LW'(cfg_reg.message_length);
        total_bits = {len_sat, 3'b000};
        bad = (cfg_reg.bits_per_component == 4'd0) || (cfg_reg.bits_per_component > 4'd8) ||
              (32'(total_bits) > 32'(cfg_reg.pixel_count));

        p0  = item.frame_start ? 24'd0 : pos_reg;
        b1x = 6'(cfg_reg.bits_per_component);
        b2x = 6'({cfg_reg.bits_per_component, 1'b0});
        b3x = b1x + b2x;
        q0  = {2'b00, p0};
        q1  = q0 + 26'(b1x);
        q2  = q0 + 26'(b2x);
        tb  = 26'(total_bits);
        h0  = q0 < tb;
        h1  = q1 < tb;
        h2  = q2 < tb;

        if (cfg_reg.all_channels)
            adv = h2 ? b3x : (h1 ? b2x : (h0 ? b1x : 6'd0));
        else
            adv = h0 ? b1x : 6'd0;

        pixel_accept = push && !q_full && (item.cmd == lsbse_pkg::CMD_PIXEL);
        pos_next     = pos_reg;
        if (pixel_accept)
            pos_next = bad ? p0 : (p0 + 24'(adv));
    end

    always_comb
    begin
        q_push                 = push && !q_full;
        q_entry.cmd            = item.cmd;
        q_entry.byte_address   = item.byte_address;
        q_entry.message_byte   = item.message_byte;
        q_entry.capacity_error = bad;
        q_entry.use_blue       = cfg_reg.all_channels && h0;
        q_entry.use_green      = cfg_reg.all_channels && h1;
        q_entry.use_red        = cfg_reg.all_channels ? h2 : h0;
        q_entry.bit_position   = p0;
        q_entry.blue           = item.in_blue;
        q_entry.green          = item.in_green;
        q_entry.red            = item.in_red;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.bits_per_component <= 4'd1;
            cfg_reg.all_channels       <= 1'b0;
            cfg_reg.message_length     <= 11'd0;
            cfg_reg.pixel_count        <= 24'd0;
            pos_reg                    <= 24'd0;
        end
        else
        begin
            cfg_reg <= cfg_next;
            pos_reg <= pos_next;
        end
    end

endmodule

@@ rtl/lsbse_queue.sv @@
module lsbse_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  lsbse_pkg::entry_t wr_entry,
    output logic              full,
    input  logic              rd_en,
    output lsbse_pkg::entry_t rd_entry,
    output logic              empty
);

    localparam int DEPTH = lsbse_pkg::QUEUE_DEPTH;
    localparam int PW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    lsbse_pkg::entry_t slot_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg;
    logic [PW-1:0] rd_ptr_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          do_wr;
    logic          do_rd;

    assign full     = (count_reg == CW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign rd_entry = slot_reg[rd_ptr_reg];

    always_comb
    begin
        do_wr       = wr_en && !full;
        do_rd       = rd_en && !empty;
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_rd)
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_wr && !do_rd)
            count_next = count_reg + 1'b1;
        else if (do_rd && !do_wr)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            slot_reg[wr_ptr_reg] <= wr_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

@@ rtl/lsbse_back.sv @@
module lsbse_back #(
    parameter int MSG_BYTES = lsbse_pkg::MSG_BYTES
) (
    input  logic                clk,
    input  logic                rst_n,
    input  lsbse_pkg::cfg_t     cfg,
    input  logic                q_empty,
    input  lsbse_pkg::entry_t   q_entry,
    output logic                q_pop,
    output logic                empty,
    input  logic                pop,
    output lsbse_pkg::result_t  result
);

    localparam int NB  = lsbse_pkg::BANKS;
    localparam int BD  = (MSG_BYTES + NB - 1) / NB;
    localparam int BAW = (BD > 1) ? $clog2(BD) : 1;
    localparam int LW  = $clog2(MSG_BYTES + 1);
    localparam int BW  = LW + 3;

    logic [LW-1:0]  len_sat;
    logic [LW-1:0]  idx;
    logic [LW+1:0]  idx_ext;
    logic [LW+1:0]  len_ext;
    logic [3:0]     vmask;
    logic           s1_adv;
    logic           issue_ready;
    logic           wr_en;
    logic           rd_en;
    logic [BAW+9:0] wa_ext;
    logic [BAW-1:0] waddr;
    logic [7:0]     rdata [NB];

    logic           s1_valid_reg;
    logic           s1_valid_next;
    logic           s1_err_reg;
    logic           s1_use_blue_reg;
    logic           s1_use_green_reg;
    logic           s1_use_red_reg;
    logic [2:0]     s1_start_reg;
    logic [1:0]     s1_lane_reg;
    logic [3:0]     s1_vmask_reg;
    logic [7:0]     s1_blue_reg;
    logic [7:0]     s1_green_reg;
    logic [7:0]     s1_red_reg;

    logic           out_valid_reg;
    logic           out_valid_next;
    lsbse_pkg::result_t out_reg;
    lsbse_pkg::result_t out_next;

    logic [31:0]    win;
    logic [3:0]     b;
    logic [7:0]     mask;
    logic [5:0]     o_blue;
    logic [5:0]     o_green;
    logic [5:0]     o_red;

    function automatic logic [7:0] embed(input logic [7:0] comp, input logic [5:0] off,
                                         input logic [31:0] w, input logic [3:0] nb,
                                         input logic [7:0] m);
        logic [5:0]  sh;
        logic [31:0] shifted;
        sh      = 6'd32 - off - 6'(nb);
        shifted = w >> sh;
        return (comp & ~m) | (shifted[7:0] & m);
    endfunction

    assign empty  = !out_valid_reg;
    assign result = out_reg;

    always_comb
    begin
        if (32'(cfg.message_length) > 32'(MSG_BYTES))
            len_sat = LW'(MSG_BYTES);
        else
            len_sat = LW'(cfg.message_length);

        s1_adv      = !out_valid_reg || pop;
        issue_ready = !s1_valid_reg || s1_adv;
        q_pop       = issue_ready && !q_empty;
        wr_en       = q_pop && (q_entry.cmd == lsbse_pkg::CMD_WRITE) &&
                      (32'(q_entry.byte_address) < 32'(MSG_BYTES));
        rd_en       = q_pop && (q_entry.cmd == lsbse_pkg::CMD_PIXEL);
        wa_ext      = (BAW + 10)'(q_entry.byte_address);
        waddr       = wa_ext[BAW+1:2];

        idx     = q_entry.bit_position[BW-1:3];
        idx_ext = (LW + 2)'(idx);
        len_ext = (LW + 2)'(len_sat);
        for (int k = 0; k < NB; k++)
            vmask[k] = (idx_ext + (LW + 2)'(k)) < len_ext;

        s1_valid_next = s1_valid_reg;
        if (issue_ready)
            s1_valid_next = rd_en;
    end

    for (genvar j = 0; j < NB; j++)
    begin : g_bank
        logic [7:0]     mem [BD];
        logic [7:0]     rd_reg;
        logic [1:0]     kj;
        logic [LW+1:0]  ij;
        logic [BAW-1:0] raddr;

        always_comb
        begin
            kj    = 2'(2'(j) - idx[1:0]);
            ij    = idx_ext + (LW + 2)'(kj);
            raddr = ij[BAW+1:2];
        end

        always_ff @(posedge clk)
        begin
            if (wr_en && (q_entry.byte_address[1:0] == 2'(j)))
                mem[waddr] <= q_entry.message_byte;
            if (rd_en)
                rd_reg <= mem[raddr];
        end

        assign rdata[j] = rd_reg;
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            s1_err_reg       <= q_entry.capacity_error;
            s1_use_blue_reg  <= q_entry.use_blue;
            s1_use_green_reg <= q_entry.use_green;
            s1_use_red_reg   <= q_entry.use_red;
            s1_start_reg     <= q_entry.bit_position[2:0];
            s1_lane_reg      <= idx[1:0];
            s1_vmask_reg     <= vmask;
            s1_blue_reg      <= q_entry.blue;
            s1_green_reg     <= q_entry.green;
            s1_red_reg       <= q_entry.red;
        end
    end

    always_comb
    begin
        for (int k = 0; k < NB; k++)
            win[31 - 8 * k -: 8] = s1_vmask_reg[k] ? rdata[2'(s1_lane_reg + 2'(k))] : 8'd0;

        b       = cfg.bits_per_component;
        mask    = 8'((9'd1 << b) - 9'd1);
        o_blue  = 6'(s1_start_reg);
        o_green = o_blue + 6'(b);
        o_red   = cfg.all_channels ? (o_blue + 6'({b, 1'b0})) : o_blue;

        if (s1_err_reg)
        begin
            out_next.out_blue       = 8'd0;
            out_next.out_green      = 8'd0;
            out_next.out_red        = 8'd0;
            out_next.capacity_error = 1'b1;
        end
        else
        begin
            out_next.out_blue  = s1_use_blue_reg  ? embed(s1_blue_reg, o_blue, win, b, mask)
                                                  : s1_blue_reg;
            out_next.out_green = s1_use_green_reg ? embed(s1_green_reg, o_green, win, b, mask)
                                                  : s1_green_reg;
            out_next.out_red   = s1_use_red_reg   ? embed(s1_red_reg, o_red, win, b, mask)
                                                  : s1_red_reg;
            out_next.capacity_error = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (s1_adv)
            out_valid_next = s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && s1_valid_reg)
            out_reg <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

@@ rtl/lsb_stego_pixel_embedder.sv @@
// Channel   Handshake          Payload
// item      push / full        cmd, byte_address, message_byte, frame_start, in_blue/green/red
// result    empty / pop        out_blue, out_green, out_red, capacity_error
// config    cfg_we             cfg_index, cfg_data
//
// One word per cycle sustained in both directions while result is popped and the queue
// is not full; a pixel reaches result via queue write, bank read and output register.
// The message store is four interleaved byte banks, one read port each, so a
// pixel fetches its whole four-byte window at once, one byte from each bank.
// Reset clears the bit position, queue and pipeline; the store is not cleared.
// A held result stalls the back pipeline; the queue absorbs up to four words.
module lsb_stego_pixel_embedder #(
    parameter int MSG_BYTES = lsbse_pkg::MSG_BYTES
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  lsbse_pkg::cfg_index_t cfg_index,
    input  logic [23:0]           cfg_data,
    input  logic                  push,
    output logic                  full,
    input  lsbse_pkg::item_t      item,
    output logic                  empty,
    input  logic                  pop,
    output lsbse_pkg::result_t    result
);

    lsbse_pkg::cfg_t   cfg;
    lsbse_pkg::entry_t q_wr_entry;
    lsbse_pkg::entry_t q_rd_entry;
    logic              q_push;
    logic              q_pop;
    logic              q_empty;

    lsbse_front #(
        .MSG_BYTES (MSG_BYTES)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .push      (push),
        .item      (item),
        .q_full    (full),
        .q_push    (q_push),
        .q_entry   (q_wr_entry),
        .cfg       (cfg)
    );

    lsbse_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (q_push),
        .wr_entry (q_wr_entry),
        .full     (full),
        .rd_en    (q_pop),
        .rd_entry (q_rd_entry),
        .empty    (q_empty)
    );

    lsbse_back #(
        .MSG_BYTES (MSG_BYTES)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .q_empty (q_empty),
        .q_entry (q_rd_entry),
        .q_pop   (q_pop),
        .empty   (empty),
        .pop     (pop),
        .result  (result)
    );

endmodule
